// ===== design/graph_reachability_counter_core_defines.svh =====
// Assertion macros shared by the reachability counter RTL.
`ifndef GRAPH_REACHABILITY_COUNTER_CORE_DEFINES_SVH
`define GRAPH_REACHABILITY_COUNTER_CORE_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define GRC_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define GRC_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GRC_IMPLIES_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/grc_pkg.sv =====
// Shared types and constants of the reachability counter.
package grc_pkg;

  localparam int MAX_NODES_DEF = 64;

  // Fixed field widths
  localparam int NODE_W      = 6;
  localparam int NUM_NODES_W = 7;
  localparam int COUNT_W     = 7;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_NODES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_NODE = 1'b1;

  localparam logic [NUM_NODES_W-1:0] NUM_NODES_RST  = 7'd64;
  localparam logic [NODE_W-1:0]      START_NODE_RST = 6'd0;

  typedef struct packed {
    logic              edge_present;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] visited_count;
    logic               all_reached;
  } out_item_t;

endpackage

// ===== design/graph_reachability_counter_core.sv =====
// Top level of the reachability counter: edge loading, depth-first walk, result.
//
// Edge transactions load one directed edge per cycle into an adjacency bit
// matrix held in a RAM (one row per source node); a row valid bit makes an
// unwritten row read as all zero, so clearing the valid bits clears the matrix
// with each result and no clearing pass is needed. The transaction with last
// set starts a depth-first walk from start_node using a stack RAM. For each
// popped node the walk reads the stack RAM and then the adjacency RAM, then
// pushes one new neighbor per cycle. Input is blocked during the walk; a
// finished result waits in the output register while the next graph loads.
`include "graph_reachability_counter_core_defines.svh"

module graph_reachability_counter_core #(
  parameter int MAX_NODES = grc_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  grc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output grc_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [grc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [grc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [grc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import grc_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_FLUSH = 8'b0000_0010,
    S_START = 8'b0000_0100,
    S_POP   = 8'b0000_1000,
    S_NODE  = 8'b0001_0000,
    S_ROW   = 8'b0010_0000,
    S_PUSH  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_NODES_W-1:0] num_nodes_r;
  logic [NODE_W-1:0]      start_node_r;
  logic [CFG_IDX_W-1:0]   cfg_idx;

  // Adjacency storage and load pipeline
  logic [MAX_NODES-1:0] row_valid_r, row_valid_nxt;
  logic                 rd_ok_r;
  logic [NW-1:0]        rd_addr_r;
  logic                 fwd_valid_r, fwd_valid_nxt;
  logic [NW-1:0]        fwd_row_r, fwd_row_nxt;
  logic [MAX_NODES-1:0] fwd_data_r, fwd_data_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [NW-1:0]        pend_row_r, pend_row_nxt;
  logic [NW-1:0]        pend_col_r, pend_col_nxt;

  // Walk state
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [CW-1:0]        tally_r, tally_nxt;
  logic [CW-1:0]        sp_r, sp_nxt;
  logic [CW-1:0]        sp_dec;
  logic [MAX_NODES-1:0] cand_r, cand_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // RAM ports
  logic                 adj_we;
  logic [NW-1:0]        adj_waddr, adj_raddr;
  logic [MAX_NODES-1:0] adj_wdata, adj_rdata;
  logic                 stk_we;
  logic [NW-1:0]        stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  // Datapath helpers
  logic [CW-1:0]        n_now;
  logic [MAX_NODES-1:0] nmask;
  logic [MAX_NODES-1:0] row_now;
  logic [MAX_NODES-1:0] lowest;
  logic [NW-1:0]        pick_idx;
  logic                 edge_ok;
  logic                 start_ok;
  logic [NW-1:0]        start_idx;

  grc_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  grc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Configuration registers
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_nodes_r  <= NUM_NODES_RST;
      start_node_r <= START_NODE_RST;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_NUM_NODES:  num_nodes_r  <= pwdata[NUM_NODES_W-1:0];
        REG_START_NODE: start_node_r <= pwdata[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NUM_NODES:  prdata = CFG_DATA_W'(num_nodes_r);
      REG_START_NODE: prdata = CFG_DATA_W'(start_node_r);
      default:        prdata = '0;
    endcase
  end

  // Node count in force, saturated at MAX_NODES, and its bit mask
  always_comb begin
    if (32'(num_nodes_r) > MAX_NODES) begin
      n_now = CW'(MAX_NODES);
    end else begin
      n_now = CW'(num_nodes_r);
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      nmask[i] = (32'(i) < 32'(n_now));
    end
  end

  assign edge_ok   = in_data.edge_present && (32'(in_data.from_node) < 32'(n_now)) &&
                     (32'(in_data.to_node) < 32'(n_now));
  assign start_ok  = (32'(start_node_r) < 32'(n_now));
  assign start_idx = NW'(start_node_r);
  assign sp_dec    = sp_r - 1'b1;

  // Row read data: forward the latest write, unwritten rows read as zero
  assign row_now = (fwd_valid_r && (fwd_row_r == rd_addr_r)) ? fwd_data_r :
                   (rd_ok_r ? adj_rdata : '0);

  // Lowest pending neighbor
  assign lowest = cand_r & (~cand_r + 1'b1);
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (lowest[i]) begin
        pick_idx = pick_idx | NW'(i);
      end
    end
  end

  // Main control
  always_comb begin
    state_nxt      = state_r;
    row_valid_nxt  = row_valid_r;
    fwd_valid_nxt  = fwd_valid_r;
    fwd_row_nxt    = fwd_row_r;
    fwd_data_nxt   = fwd_data_r;
    pend_valid_nxt = 1'b0;
    pend_row_nxt   = pend_row_r;
    pend_col_nxt   = pend_col_r;
    visited_nxt    = visited_r;
    tally_nxt      = tally_r;
    sp_nxt         = sp_r;
    cand_nxt       = cand_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    in_ready  = (state_r == S_LOAD);
    adj_raddr = NW'(in_data.from_node);
    adj_we    = 1'b0;
    adj_waddr = pend_row_r;
    adj_wdata = row_now | (MAX_NODES'(1) << pend_col_r);
    stk_we    = 1'b0;
    stk_waddr = sp_r[NW-1:0];
    stk_wdata = pick_idx;
    stk_raddr = sp_dec[NW-1:0];

    // Edge write-back, second half of the read-modify-write
    if (pend_valid_r) begin
      adj_we                    = 1'b1;
      row_valid_nxt[pend_row_r] = 1'b1;
      fwd_valid_nxt             = 1'b1;
      fwd_row_nxt               = pend_row_r;
      fwd_data_nxt              = adj_wdata;
    end

    // Edge transaction: issue the row read
    if (in_valid && in_ready) begin
      if (edge_ok) begin
        pend_valid_nxt = 1'b1;
        pend_row_nxt   = NW'(in_data.from_node);
        pend_col_nxt   = NW'(in_data.to_node);
      end
      if (in_data.last) begin
        state_nxt = S_FLUSH;
      end
    end

    case (state_r)
      S_LOAD: ;
      // let the closing edge reach the RAM
      S_FLUSH: begin
        state_nxt = S_START;
      end
      S_START: begin
        if (start_ok) begin
          visited_nxt            = '0;
          visited_nxt[start_idx] = 1'b1;
          tally_nxt              = CW'(1);
          stk_we                 = 1'b1;
          stk_wdata              = start_idx;
          sp_nxt                 = CW'(1);
          state_nxt              = S_POP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          sp_nxt    = sp_dec;
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        adj_raddr = stk_rdata;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cand_nxt  = row_now & ~visited_r & nmask;
        state_nxt = S_PUSH;
      end
      // one new neighbor per cycle: mark, count, push
      S_PUSH: begin
        if (cand_r == '0) begin
          state_nxt = S_POP;
        end else begin
          visited_nxt = visited_r | lowest;
          tally_nxt   = tally_r + 1'b1;
          stk_we      = 1'b1;
          sp_nxt      = sp_r + 1'b1;
          cand_nxt    = cand_r & ~lowest;
        end
      end
      // hand over the result and clear the graph
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.visited_count = COUNT_W'(tally_r);
          out_data_nxt.all_reached   = (n_now != '0) && (tally_r == n_now);
          row_valid_nxt              = '0;
          fwd_valid_nxt              = 1'b0;
          visited_nxt                = '0;
          tally_nxt                  = '0;
          sp_nxt                     = '0;
          state_nxt                  = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      row_valid_r  <= '0;
      rd_ok_r      <= 1'b0;
      fwd_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      visited_r    <= '0;
      tally_r      <= '0;
      sp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_valid_r  <= row_valid_nxt;
      rd_ok_r      <= row_valid_r[adj_raddr];
      fwd_valid_r  <= fwd_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      visited_r    <= visited_nxt;
      tally_r      <= tally_nxt;
      sp_r         <= sp_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_addr_r  <= adj_raddr;
    fwd_row_r  <= fwd_row_nxt;
    fwd_data_r <= fwd_data_nxt;
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    cand_r     <= cand_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `GRC_HOLDS(a_tally_matches_visited, tally_r == CW'($countones(visited_r)), "tally differs from visited map")
  `GRC_HOLDS(a_stack_within_tally, sp_r <= tally_r, "stack deeper than reached nodes")
  `GRC_IMPLIES(a_walk_after_flush, state_r == S_START, !pend_valid_r, "walk starts with edge write pending")
  `GRC_IMPLIES_NEXT(a_done_clears, (state_r == S_DONE) && (!out_valid_r || out_ready), out_valid_r && (row_valid_r == '0) && (sp_r == '0), "result without graph clear")

endmodule

// ===== design/grc_ram.sv =====
// Generic simple dual-port RAM with registered read (read-first).
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/sv/tb_graph_reachability_counter_core.sv =====
// Self-checking bench for the graph reachability counter core.
`timescale 1ns / 1ps

module tb_graph_reachability_counter_core;
  import grc_pkg::*;

  localparam int NODES          = MAX_NODES_DEF;
  localparam int RANDOM_ITEMS   = 630;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 400;
  localparam int HOLDOFF_CYCLES = 1500;
  localparam int BURST_ITEMS    = 4;     // closing transactions offered during the hold-off
  localparam longint TIMEOUT_NS = 20_000_000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  value;
    in_item_t               item;
    bit                     has_exp;
    out_item_t              exp;
  } script_row_t;

  // per-transaction tag: a hand-written count overrides the computed one
  typedef struct packed {
    logic      known;
    out_item_t value;
  } count_tag_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow copy of the graph and the registers
  logic [NODES-1:0]       adj_rows [NODES];
  logic [NUM_NODES_W-1:0] num_nodes_q;
  logic [NODE_W-1:0]      start_node_q;

  out_item_t  expected_counts [$];
  count_tag_t count_tags [$];
  int         errors = 0;
  int         items_sent = 0;
  int         tx_calm = 0;
  bit         hold_req = 1'b0;

  graph_reachability_counter_core #(
    .MAX_NODES(NODES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("graph_reachability_counter_core regression: fail");
    $finish;
  end

  function automatic int nodes_in_use();
    return (num_nodes_q > NODES) ? NODES : int'(num_nodes_q);
  endfunction

  // Load one edge; on the closing transaction walk the graph and count reached nodes.
  function automatic bit count_reachable(input in_item_t it, output out_item_t res);
    int          n;
    int          node;
    int          tally;
    int          stack [$];
    logic [NODES-1:0] seen;
    n = nodes_in_use();
    res = '0;
    if (it.edge_present && it.from_node < n && it.to_node < n)
      adj_rows[it.from_node][it.to_node] = 1'b1;
    if (!it.last)
      return 1'b0;
    seen = '0;
    tally = 0;
    if (start_node_q < n) begin
      seen[start_node_q] = 1'b1;
      tally = 1;
      stack.push_back(int'(start_node_q));
    end
    while (stack.size() > 0) begin
      node = stack.pop_back();
      for (int nb = 0; nb < n; nb++) begin
        if (adj_rows[node][nb] && !seen[nb]) begin
          seen[nb] = 1'b1;
          tally++;
          stack.push_back(nb);
        end
      end
    end
    res.visited_count = COUNT_W'(tally);
    res.all_reached   = (n != 0 && tally == n);
    for (int r = 0; r < NODES; r++)
      adj_rows[r] = '0;
    return 1'b1;
  endfunction

  function automatic int pause_len();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(12, 50);
  endfunction

  // Directed-table row builders
  function automatic script_row_t load_row(input bit present, input int src, input int dst);
    script_row_t row;
    row.kind    = ROW_ITEM;
    row.reg_idx = '0;
    row.value   = '0;
    row.item    = '{present, NODE_W'(src), NODE_W'(dst), 1'b0};
    row.has_exp = 1'b0;
    row.exp     = '0;
    return row;
  endfunction

  function automatic script_row_t close_row(input bit present, input int src, input int dst,
                                            input int cnt, input bit all_hit);
    script_row_t row;
    row = load_row(present, src, dst);
    row.item.last = 1'b1;
    row.has_exp   = 1'b1;
    row.exp       = '{COUNT_W'(cnt), all_hit};
    return row;
  endfunction

  function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    script_row_t row;
    row = load_row(1'b0, 0, 0);
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.value   = CFG_DATA_W'(val);
    return row;
  endfunction

  // Offer one transaction after a random gap and wait for it to be taken.
  task automatic push_item(input in_item_t it, input bit known, input out_item_t want);
    int         gap;
    count_tag_t tag;
    gap = 0;
    if (tx_calm > 0)
      tx_calm--;
    else if ($urandom_range(0, 99) < 3)
      tx_calm = $urandom_range(30, 100);
    else if ($urandom_range(0, 99) >= 55)
      gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tag.known = known;
    tag.value = want;
    count_tags.push_back(tag);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Register write once the block has gone quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random graph: a chain from the root, random in-range edges, or noise.
  task automatic send_graph(input int span, input int root);
    int       mode;
    int       edges;
    int       hop;
    in_item_t it;
    mode = $urandom_range(0, 9);
    if (mode < 3 && span > 1)
      edges = (span > 48) ? 48 : span - 1;
    else
      edges = $urandom_range(0, (span > 20) ? 40 : 2 * span + 2);
    for (int e = 0; e < edges; e++) begin
      it = '0;
      if (mode < 3 && span > 1) begin
        hop = (root + e) % span;
        it.edge_present = 1'b1;
        it.from_node    = NODE_W'(hop);
        it.to_node      = NODE_W'((hop + 1) % span);
      end else if (span > 0 && $urandom_range(0, 99) < 85) begin
        it.edge_present = 1'b1;
        it.from_node    = NODE_W'($urandom_range(0, span - 1));
        it.to_node      = NODE_W'($urandom_range(0, span - 1));
      end else begin
        it.edge_present = 1'($urandom_range(0, 1));
        it.from_node    = NODE_W'($urandom_range(0, 63));
        it.to_node      = NODE_W'($urandom_range(0, 63));
      end
      push_item(it, 1'b0, '0);
    end
    // now and then the node count moves between loading and the walk
    if ($urandom_range(0, 9) == 0)
      write_reg(REG_NUM_NODES, CFG_DATA_W'($urandom_range(0, 127)));
    it = '0;
    it.edge_present = 1'($urandom_range(0, 1));
    it.from_node    = NODE_W'((span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, 63));
    it.to_node      = NODE_W'($urandom_range(0, 63));
    it.last         = 1'b1;
    push_item(it, 1'b0, '0);
  endtask

  // Result checking, register shadowing and prediction on each handshake.
  always @(posedge clk) begin : scoreboard
    out_item_t  want;
    out_item_t  computed;
    count_tag_t tag;
    if (!rst_n) begin
      num_nodes_q  = NUM_NODES_RST;
      start_node_q = START_NODE_RST;
      for (int r = 0; r < NODES; r++)
        adj_rows[r] = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual count %0d all_reached %0b",
                   $time, out_data.visited_count, out_data.all_reached);
        end else begin
          want = expected_counts.pop_front();
          if (out_data.visited_count !== want.visited_count) begin
            errors++;
            $display("%0t: visited_count mismatch: expected %0d, actual %0d",
                     $time, want.visited_count, out_data.visited_count);
          end
          if (out_data.all_reached !== want.all_reached) begin
            errors++;
            $display("%0t: all_reached mismatch: expected %0b, actual %0b",
                     $time, want.all_reached, out_data.all_reached);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_NUM_NODES:  num_nodes_q  = pwdata[NUM_NODES_W-1:0];
          REG_START_NODE: start_node_q = pwdata[NODE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        tag = (count_tags.size() > 0) ? count_tags.pop_front() : '0;
        if (count_reachable(in_data, computed))
          expected_counts.push_back(tag.known ? tag.value : computed);
      end
    end
  end

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin : receiver
    int stall_left;
    int calm_left;
    bit held;
    stall_left = 0;
    calm_left  = 0;
    held       = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && hold_req) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        calm_left = $urandom_range(50, 200);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 60) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = pause_len() - 1;
        out_ready <= 1'b0;
      end
    end
  end

  // Stimulus: directed table, then random graphs under random settings.
  initial begin : stimulus
    script_row_t           script [$];
    int                    count_cfg;
    int                    span;
    int                    root;
    int                    graphs;
    logic [CFG_DATA_W-1:0] word;
    in_item_t              burst;
    rst_n   <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    script = '{
      close_row(1'b0, 63, 63, 1, 1'b0),          // empty graph after reset
      load_row (1'b1, 0, 63),
      close_row(1'b1, 63, 0, 2, 1'b0),           // extreme node ids
      cfg_row  (REG_NUM_NODES, 1),
      close_row(1'b1, 0, 0, 1, 1'b1),            // single node, self loop
      cfg_row  (REG_NUM_NODES, 0),
      close_row(1'b1, 0, 0, 0, 1'b0),            // zero node count
      cfg_row  (REG_NUM_NODES, 2),
      close_row(1'b1, 0, 1, 2, 1'b1),
      cfg_row  (REG_NUM_NODES, 127),             // saturates at 64
      load_row (1'b1, 5, 6),
      load_row (1'b1, 0, 0),
      load_row (1'b1, 0, 0),                     // duplicate edge
      close_row(1'b1, 0, 5, 3, 1'b0),
      cfg_row  (REG_START_NODE, 63),
      load_row (1'b1, 63, 62),
      close_row(1'b1, 62, 63, 2, 1'b0),
      cfg_row  (REG_NUM_NODES, 10),
      close_row(1'b1, 1, 2, 0, 1'b0),            // start above node count
      cfg_row  (REG_START_NODE, 9),
      cfg_row  (REG_NUM_NODES, 64),
      load_row (1'b1, 9, 63),
      cfg_row  (REG_NUM_NODES, 10),              // count shrinks after loading
      load_row (1'b1, 12, 9),                    // source out of range
      close_row(1'b0, 63, 63, 1, 1'b0),
      cfg_row  (REG_NUM_NODES, 40),
      load_row (1'b1, 9, 50),                    // target out of range
      cfg_row  (REG_NUM_NODES, 64),
      close_row(1'b1, 0, 1, 1, 1'b0)
    };
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG)
        write_reg(script[i].reg_idx, script[i].value);
      else
        push_item(script[i].item, script[i].has_exp, script[i].exp);
    end

    // closing transactions keep coming while the receiver holds off,
    // so the output register and the finished walk fill and input stalls
    hold_req = 1'b1;
    repeat (BURST_ITEMS) begin
      burst      = '0;
      burst.last = 1'b1;
      push_item(burst, 1'b0, '0);
    end

    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       count_cfg = 0;
        1:       count_cfg = 1;
        2:       count_cfg = NODES;
        3:       count_cfg = $urandom_range(65, 127);
        4, 5:    count_cfg = $urandom_range(13, 63);
        default: count_cfg = $urandom_range(2, 12);
      endcase
      span = (count_cfg > NODES) ? NODES : count_cfg;
      root = (span > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, span - 1)
                                                      : $urandom_range(0, 63);
      // upper bits of the register word are don't-care
      word = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom) : '0;
      word[NUM_NODES_W-1:0] = NUM_NODES_W'(count_cfg);
      write_reg(REG_NUM_NODES, word);
      word = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom) : '0;
      word[NODE_W-1:0] = NODE_W'(root);
      write_reg(REG_START_NODE, word);
      graphs = $urandom_range(2, 6);
      repeat (graphs) begin
        if (items_sent < RANDOM_ITEMS)
          send_graph(span, root);
      end
    end

    // drain outstanding results
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("graph_reachability_counter_core regression: pass");
    else
      $display("graph_reachability_counter_core regression: fail");
    $finish;
  end

endmodule

// ===== graph_reachability_counter_core.f =====
+incdir+design
design/grc_pkg.sv
design/grc_ram.sv
design/graph_reachability_counter_core.sv
tb/sv/tb_graph_reachability_counter_core.sv
